// ----- hw/rtl/hbcsd_pkg.sv -----
`default_nettype none

package hbcsd_pkg;

	// request codes
	localparam logic [2:0] FN_CFG_RD   = 3'd0;
	localparam logic [2:0] FN_CFG_WR   = 3'd1;
	localparam logic [2:0] FN_SMM_ENTR = 3'd2;
	localparam logic [2:0] FN_SMM_EXIT = 3'd3;
	localparam logic [2:0] FN_DECODE   = 3'd4;

	localparam int NUM_REGIONS = 14;
	localparam int NUM_PAM     = 7;

	localparam logic [3:0] REGION_BIOS  = 4'd0;
	localparam logic [3:0] REGION_SMRAM = 4'd13;

	// routing bits: bit 0 read internal, bit 1 write internal
	localparam logic [1:0] ROUTE_EXT = 2'b00;
	localparam logic [1:0] ROUTE_INT = 2'b11;

	localparam logic [7:0] OFF_CMD_LO   = 8'h04;
	localparam logic [7:0] OFF_CMD_HI   = 8'h05;
	localparam logic [7:0] OFF_STS_LO   = 8'h06;
	localparam logic [7:0] OFF_STS_HI   = 8'h07;
	localparam logic [7:0] OFF_RO_LO    = 8'h10;
	localparam logic [7:0] OFF_RO_HI    = 8'h4E;
	localparam logic [7:0] OFF_PAM0     = 8'h59;
	localparam logic [7:0] OFF_PAM6     = 8'h5F;
	localparam logic [7:0] OFF_SMRAM    = 8'h72;
	localparam logic [7:0] ABSENT_BYTE  = 8'hFF;

	localparam logic [7:0] SMRAM_RESET  = 8'h02;
	localparam logic [7:0] SMRAM_WMASK  = 8'h78;
	localparam logic [7:0] SMRAM_FIXED  = 8'h02;
	localparam int         SMRAM_OPEN   = 6;
	localparam int         SMRAM_LOCK   = 4;
	localparam int         SMRAM_EN     = 3;

	localparam logic [19:0] ADDR_SMRAM_BASE  = 20'hA0000;
	localparam logic [19:0] ADDR_SHADOW_BASE = 20'hC0000;
	localparam logic [19:0] ADDR_BIOS_BASE   = 20'hF0000;
	// first 16 KiB block number of the shadow range, less one for region 1
	localparam logic [5:0]  SHADOW_BLK_BIAS  = 6'd47;

	typedef struct packed {
		logic [2:0]  func;
		logic [2:0]  function_number;
		logic [7:0]  reg_offset;
		logic [7:0]  write_byte;
		logic [19:0] mem_address;
		logic        mem_is_write;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       routed_internal;
		logic       in_managed_region;
	} rsp_t;

	// power-on contents of the configuration space
	function automatic logic [7:0] reset_byte(input logic [7:0] off);
		logic [7:0] b;
		case (off)
			8'h00: b = 8'h86;
			8'h01: b = 8'h80;
			8'h02: b = 8'h37;
			8'h03: b = 8'h12;
			8'h04: b = 8'h06;
			8'h06: b = 8'h80;
			8'h07: b = 8'h02;
			8'h0B: b = 8'h06;
			8'h51: b = 8'h84;
			8'h53: b = 8'h80;
			8'h57: b = 8'h01;
			8'h58: b = 8'h10;
			8'h60: b = 8'h01;
			8'h61: b = 8'h01;
			8'h62: b = 8'h01;
			8'h63: b = 8'h01;
			8'h64: b = 8'h01;
			8'h71: b = 8'h10;
			8'h72: b = SMRAM_RESET;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// bytes that ignore config writes
	function automatic logic write_ignored(input logic [7:0] off);
		logic ign;
		ign = (off >= OFF_RO_LO) && (off <= OFF_RO_HI);
		case (off)
			8'h00, 8'h01, 8'h02, 8'h03,
			8'h08, 8'h09, 8'h0A, 8'h0B,
			8'h0C, 8'h0E: ign = 1'b1;
			default: ;
		endcase
		return ign;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hbcsd_ram.sv -----
`default_nettype none

module hbcsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/host_bridge_config_and_shadow_decode_unit.sv -----
`default_nettype none

// channel   ports               handshake
// -------   -----------------   ----------------------------------------
// request   req (req_t)         taken on start && !busy
// result    rsp (rsp_t)         valid for one cycle while done is high
//
// One word in, one word out, through an input register, then a result
// register. A new request is taken every cycle; busy stays low.
// Config bytes live in a 256x8 RAM with a valid bit per byte; an unwritten
// byte reads its power-on value, so no clearing pass runs after reset.
// A write followed at once by a read of the same byte is forwarded.
// The receiver cannot stall; results are never held back.

module host_bridge_config_and_shadow_decode_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire hbcsd_pkg::req_t req,
	output logic                done,
	output hbcsd_pkg::rsp_t     rsp
);

	logic            accept;
	logic            v_s1;
	hbcsd_pkg::req_t req_s1;

	logic [255:0] valid_q;
	logic [7:0]   pam_q [hbcsd_pkg::NUM_PAM];
	logic [7:0]   smram_q;
	logic [1:0]   routing_q [hbcsd_pkg::NUM_REGIONS];

	logic [7:0]   pam_d [hbcsd_pkg::NUM_PAM];
	logic [7:0]   smram_d;
	logic [1:0]   routing_d [hbcsd_pkg::NUM_REGIONS];

	logic         ram_we;
	logic [7:0]   ram_wdata;
	logic [7:0]   ram_rdata;

	logic         byp_v_q;
	logic [7:0]   byp_addr_q;
	logic [7:0]   byp_data_q;

	logic         done_q;
	hbcsd_pkg::rsp_t rsp_q;
	hbcsd_pkg::rsp_t rsp_d;

	logic         cfg_wr;
	logic [7:0]   off;
	logic [7:0]   wd;
	logic [2:0]   pam_idx;
	logic [7:0]   pam_old;
	logic [3:0]   reg_lo;
	logic [3:0]   reg_hi;
	logic [7:0]   sm;
	logic [7:0]   cur_byte;
	logic [3:0]   blk_rel;
	logic [3:0]   region;
	logic [1:0]   route;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	hbcsd_ram #(
		.WIDTH(8),
		.DEPTH(256)
	) u_cfg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(req_s1.reg_offset),
		.wdata(ram_wdata),
		.raddr(req.reg_offset),
		.rdata(ram_rdata)
	);

	always_comb begin
		off     = req_s1.reg_offset;
		wd      = req_s1.write_byte;
		cfg_wr  = v_s1 && (req_s1.func == hbcsd_pkg::FN_CFG_WR)
			&& (req_s1.function_number == 3'd0);
		pam_idx = 3'(off - hbcsd_pkg::OFF_PAM0);
		pam_old = pam_q[pam_idx];
		reg_lo  = 4'({pam_idx, 1'b0} - 4'd1);
		reg_hi  = 4'({pam_idx, 1'b0});

		pam_d     = pam_q;
		smram_d   = smram_q;
		routing_d = routing_q;
		ram_we    = cfg_wr && !hbcsd_pkg::write_ignored(off);
		ram_wdata = wd;

		// SMRAM byte: keep lock sticky, force open low and freeze enable once locked
		sm = (wd & hbcsd_pkg::SMRAM_WMASK) | hbcsd_pkg::SMRAM_FIXED;
		sm[hbcsd_pkg::SMRAM_LOCK] = sm[hbcsd_pkg::SMRAM_LOCK]
			| smram_q[hbcsd_pkg::SMRAM_LOCK];
		if (sm[hbcsd_pkg::SMRAM_LOCK]) begin
			sm[hbcsd_pkg::SMRAM_OPEN] = 1'b0;
			sm[hbcsd_pkg::SMRAM_EN]   = smram_q[hbcsd_pkg::SMRAM_EN];
		end

		case (off)
			hbcsd_pkg::OFF_CMD_LO: ram_wdata = {5'd0, 1'b1, wd[1], 1'b0};
			hbcsd_pkg::OFF_CMD_HI,
			hbcsd_pkg::OFF_STS_LO: ram_wdata = 8'h00;
			hbcsd_pkg::OFF_STS_HI: ram_wdata = 8'h02;
			hbcsd_pkg::OFF_SMRAM:  ram_wdata = sm;
			default: ;
		endcase

		if (cfg_wr) begin
			if (off == hbcsd_pkg::OFF_PAM0) begin
				pam_d[0] = wd;
				if (pam_q[0][7:4] != wd[7:4]) begin
					routing_d[hbcsd_pkg::REGION_BIOS] = wd[5:4];
				end
			end else if (off > hbcsd_pkg::OFF_PAM0 && off <= hbcsd_pkg::OFF_PAM6) begin
				pam_d[pam_idx] = wd;
				if (pam_old[3:0] != wd[3:0]) begin
					routing_d[reg_lo] = wd[1:0];
				end
				if (pam_old[7:4] != wd[7:4]) begin
					routing_d[reg_hi] = wd[5:4];
				end
			end else if (off == hbcsd_pkg::OFF_SMRAM) begin
				smram_d = sm;
				if (smram_q[hbcsd_pkg::SMRAM_OPEN] != sm[hbcsd_pkg::SMRAM_OPEN]) begin
					routing_d[hbcsd_pkg::REGION_SMRAM] = sm[hbcsd_pkg::SMRAM_OPEN]
						? hbcsd_pkg::ROUTE_INT : hbcsd_pkg::ROUTE_EXT;
				end
			end
		end

		if (v_s1 && smram_q[hbcsd_pkg::SMRAM_EN]) begin
			if (req_s1.func == hbcsd_pkg::FN_SMM_ENTR) begin
				routing_d[hbcsd_pkg::REGION_SMRAM] = hbcsd_pkg::ROUTE_INT;
			end else if (req_s1.func == hbcsd_pkg::FN_SMM_EXIT) begin
				routing_d[hbcsd_pkg::REGION_SMRAM] = hbcsd_pkg::ROUTE_EXT;
			end
		end
	end

	// result word
	always_comb begin
		if (byp_v_q && byp_addr_q == off) begin
			cur_byte = byp_data_q;
		end else if (valid_q[off]) begin
			cur_byte = ram_rdata;
		end else begin
			cur_byte = hbcsd_pkg::reset_byte(off);
		end

		blk_rel = 4'(req_s1.mem_address[19:14] - hbcsd_pkg::SHADOW_BLK_BIAS);
		if (req_s1.mem_address >= hbcsd_pkg::ADDR_BIOS_BASE) begin
			region = hbcsd_pkg::REGION_BIOS;
		end else if (req_s1.mem_address >= hbcsd_pkg::ADDR_SHADOW_BASE) begin
			region = blk_rel;
		end else begin
			region = hbcsd_pkg::REGION_SMRAM;
		end
		route = routing_q[region];

		rsp_d = '0;
		case (req_s1.func)
			hbcsd_pkg::FN_CFG_RD: begin
				rsp_d.read_byte = (req_s1.function_number != 3'd0)
					? hbcsd_pkg::ABSENT_BYTE : cur_byte;
			end
			hbcsd_pkg::FN_DECODE: begin
				if (req_s1.mem_address >= hbcsd_pkg::ADDR_SMRAM_BASE) begin
					rsp_d.in_managed_region = 1'b1;
					rsp_d.routed_internal   = req_s1.mem_is_write ? route[1] : route[0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		byp_addr_q <= off;
		byp_data_q <= ram_wdata;
		rsp_q      <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
			byp_v_q <= 1'b0;
			valid_q <= '0;
			smram_q <= hbcsd_pkg::SMRAM_RESET;
			for (int i = 0; i < hbcsd_pkg::NUM_PAM; i++) begin
				pam_q[i] <= 8'h00;
			end
			for (int i = 0; i < hbcsd_pkg::NUM_REGIONS; i++) begin
				routing_q[i] <= hbcsd_pkg::ROUTE_EXT;
			end
		end else begin
			v_s1    <= accept;
			done_q  <= v_s1;
			byp_v_q <= ram_we;
			if (ram_we) begin
				valid_q[off] <= 1'b1;
			end
			smram_q   <= smram_d;
			pam_q     <= pam_d;
			routing_q <= routing_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result word missing two cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result word without a request");

	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(smram_q[hbcsd_pkg::SMRAM_LOCK]) |-> smram_q[hbcsd_pkg::SMRAM_LOCK])
		else $error("SMRAM lock bit cleared");

	a_locked_closed: assert property (@(posedge clk) disable iff (!arst_n)
		smram_q[hbcsd_pkg::SMRAM_LOCK] |-> !smram_q[hbcsd_pkg::SMRAM_OPEN])
		else $error("SMRAM open while locked");

	a_internal_managed: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.routed_internal |-> rsp.in_managed_region)
		else $error("internal routing outside managed range");

endmodule

`default_nettype wire

// ----- test/host_bridge_config_and_shadow_decode_unit_test.sv -----
`timescale 1ns / 100ps

module host_bridge_config_and_shadow_decode_unit_test;

	// codes the block treats as no-ops
	localparam logic [2:0] FN_RSVD_LO = hbcsd_pkg::FN_DECODE + 3'd1;
	localparam logic [2:0] FN_RSVD_HI = 3'd7;

	// identity bytes that ignore writes
	localparam logic [7:0] OFF_ID_LO    = 8'h00;
	localparam logic [7:0] OFF_ID_HI    = 8'h03;
	localparam logic [7:0] OFF_CLASS_LO = 8'h08;
	localparam logic [7:0] OFF_CLASS_HI = 8'h0B;
	localparam logic [7:0] OFF_CLS      = 8'h0C;
	localparam logic [7:0] OFF_HDR      = 8'h0E;

	localparam int QUIET_LIMIT = 2000;

	class bridge_mirror;
		logic [7:0] cfg_space [256];
		logic [1:0] route [hbcsd_pkg::NUM_REGIONS];
		hbcsd_pkg::rsp_t pending_rsp [$];
		int unsigned mismatches;
		int unsigned words_in;
		int unsigned results;
		int unsigned cfg_writes;
		int unsigned decodes;
		int unsigned smm_events;

		function new();
			foreach (cfg_space[i])
				cfg_space[i] = 8'h00;
			foreach (route[i])
				route[i] = hbcsd_pkg::ROUTE_EXT;
			// power-on identity and default bytes
			cfg_space[8'h00] = 8'h86; cfg_space[8'h01] = 8'h80;
			cfg_space[8'h02] = 8'h37; cfg_space[8'h03] = 8'h12;
			cfg_space[8'h04] = 8'h06; cfg_space[8'h06] = 8'h80;
			cfg_space[8'h07] = 8'h02; cfg_space[8'h0B] = 8'h06;
			cfg_space[8'h51] = 8'h84; cfg_space[8'h53] = 8'h80;
			cfg_space[8'h57] = 8'h01; cfg_space[8'h58] = 8'h10;
			for (int i = 8'h60; i <= 8'h64; i++)
				cfg_space[i] = 8'h01;
			cfg_space[8'h71] = 8'h10;
			cfg_space[hbcsd_pkg::OFF_SMRAM] = 8'h02;
		endfunction

		// a region takes new routing only when its nibble changes
		function void set_pam(int region, logic [3:0] prior, logic [3:0] nib);
			if (prior != nib)
				route[region] = nib[1:0];
		endfunction

		function void cfg_store(logic [7:0] off, logic [7:0] val);
			logic [7:0] prior;
			logic [7:0] v;
			int base;
			prior = cfg_space[off];
			v = val;
			if ((off >= hbcsd_pkg::OFF_RO_LO && off <= hbcsd_pkg::OFF_RO_HI) ||
			    off <= OFF_ID_HI ||
			    (off >= OFF_CLASS_LO && off <= OFF_CLASS_HI) ||
			    off == OFF_CLS || off == OFF_HDR)
				return;
			case (off)
				hbcsd_pkg::OFF_CMD_LO: v = (val & 8'h02) | 8'h04;
				hbcsd_pkg::OFF_CMD_HI, hbcsd_pkg::OFF_STS_LO: v = 8'h00;
				hbcsd_pkg::OFF_STS_HI: v = 8'h02;
				hbcsd_pkg::OFF_SMRAM: begin
					v = (val & hbcsd_pkg::SMRAM_WMASK) | hbcsd_pkg::SMRAM_FIXED;
					v[hbcsd_pkg::SMRAM_LOCK] = v[hbcsd_pkg::SMRAM_LOCK]
						| prior[hbcsd_pkg::SMRAM_LOCK];
					// locked: drop open, freeze enable
					if (v[hbcsd_pkg::SMRAM_LOCK]) begin
						v[hbcsd_pkg::SMRAM_OPEN] = 1'b0;
						v[hbcsd_pkg::SMRAM_EN] = prior[hbcsd_pkg::SMRAM_EN];
					end
					if (v[hbcsd_pkg::SMRAM_OPEN] != prior[hbcsd_pkg::SMRAM_OPEN])
						route[hbcsd_pkg::REGION_SMRAM] = v[hbcsd_pkg::SMRAM_OPEN]
							? hbcsd_pkg::ROUTE_INT : hbcsd_pkg::ROUTE_EXT;
				end
				default: ;
			endcase
			if (off == hbcsd_pkg::OFF_PAM0) begin
				set_pam(hbcsd_pkg::REGION_BIOS, prior[7:4], val[7:4]);
			end else if (off > hbcsd_pkg::OFF_PAM0 && off <= hbcsd_pkg::OFF_PAM6) begin
				base = 1 + 2 * int'(off - hbcsd_pkg::OFF_PAM0 - 8'd1);
				set_pam(base, prior[3:0], val[3:0]);
				set_pam(base + 1, prior[7:4], val[7:4]);
			end
			cfg_space[off] = v;
		endfunction

		function void take_request(hbcsd_pkg::req_t r);
			hbcsd_pkg::rsp_t want;
			int region;
			want = '0;
			words_in++;
			case (r.func)
				hbcsd_pkg::FN_CFG_RD:
					want.read_byte = (r.function_number != 3'd0)
						? hbcsd_pkg::ABSENT_BYTE : cfg_space[r.reg_offset];
				hbcsd_pkg::FN_CFG_WR: begin
					cfg_writes++;
					if (r.function_number == 3'd0)
						cfg_store(r.reg_offset, r.write_byte);
				end
				hbcsd_pkg::FN_SMM_ENTR: begin
					smm_events++;
					if (cfg_space[hbcsd_pkg::OFF_SMRAM][hbcsd_pkg::SMRAM_EN])
						route[hbcsd_pkg::REGION_SMRAM] = hbcsd_pkg::ROUTE_INT;
				end
				hbcsd_pkg::FN_SMM_EXIT: begin
					smm_events++;
					if (cfg_space[hbcsd_pkg::OFF_SMRAM][hbcsd_pkg::SMRAM_EN])
						route[hbcsd_pkg::REGION_SMRAM] = hbcsd_pkg::ROUTE_EXT;
				end
				hbcsd_pkg::FN_DECODE: begin
					decodes++;
					if (r.mem_address >= hbcsd_pkg::ADDR_SMRAM_BASE) begin
						if (r.mem_address >= hbcsd_pkg::ADDR_BIOS_BASE)
							region = hbcsd_pkg::REGION_BIOS;
						else if (r.mem_address >= hbcsd_pkg::ADDR_SHADOW_BASE)
							region = 1 + int'((r.mem_address
								- hbcsd_pkg::ADDR_SHADOW_BASE) >> 14);
						else
							region = hbcsd_pkg::REGION_SMRAM;
						want.in_managed_region = 1'b1;
						want.routed_internal = route[region][r.mem_is_write];
					end
				end
				default: ;
			endcase
			pending_rsp.push_back(want);
		endfunction

		function void compare_response(hbcsd_pkg::rsp_t got);
			hbcsd_pkg::rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("result word with no request waiting");
				mismatches++;
				return;
			end
			want = pending_rsp.pop_front();
			results++;
			if (got.read_byte !== want.read_byte) begin
				$error("read_byte: expected %02h, actual %02h", want.read_byte, got.read_byte);
				mismatches++;
			end
			if (got.routed_internal !== want.routed_internal) begin
				$error("routed_internal: expected %0b, actual %0b",
					want.routed_internal, got.routed_internal);
				mismatches++;
			end
			if (got.in_managed_region !== want.in_managed_region) begin
				$error("in_managed_region: expected %0b, actual %0b",
					want.in_managed_region, got.in_managed_region);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	hbcsd_pkg::req_t req;
	logic done;
	hbcsd_pkg::rsp_t rsp;
	int unsigned quiet_cycles;

	bridge_mirror mirror = new();

	host_bridge_config_and_shadow_decode_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				mirror.take_request(req);
			if (done)
				mirror.compare_response(rsp);
		end
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic hbcsd_pkg::req_t mk(logic [2:0] fn, logic [2:0] fnum,
		logic [7:0] off, logic [7:0] data, logic [19:0] addr, logic wr);
		hbcsd_pkg::req_t r;
		r.func = fn;
		r.function_number = fnum;
		r.reg_offset = off;
		r.write_byte = data;
		r.mem_address = addr;
		r.mem_is_write = wr;
		return r;
	endfunction

	function automatic hbcsd_pkg::req_t random_word(bit allow_lock);
		hbcsd_pkg::req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			r.func = hbcsd_pkg::FN_CFG_RD;
		else if (pick < 50)
			r.func = hbcsd_pkg::FN_CFG_WR;
		else if (pick < 58)
			r.func = hbcsd_pkg::FN_SMM_ENTR;
		else if (pick < 66)
			r.func = hbcsd_pkg::FN_SMM_EXIT;
		else if (pick < 96)
			r.func = hbcsd_pkg::FN_DECODE;
		else
			r.func = 3'($urandom_range(FN_RSVD_LO, FN_RSVD_HI));
		r.function_number = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
		// steer most accesses onto the bytes with side effects
		case ($urandom_range(0, 4))
			0: r.reg_offset = hbcsd_pkg::OFF_CMD_LO + 8'($urandom_range(0, 3));
			1, 2: r.reg_offset = hbcsd_pkg::OFF_PAM0
				+ 8'($urandom_range(0, hbcsd_pkg::NUM_PAM - 1));
			3: r.reg_offset = hbcsd_pkg::OFF_SMRAM;
			default: r.reg_offset = 8'($urandom);
		endcase
		r.write_byte = 8'($urandom);
		// flip one nibble only, sometimes none, so unchanged nibbles show up
		if (r.reg_offset >= hbcsd_pkg::OFF_PAM0 && r.reg_offset <= hbcsd_pkg::OFF_PAM6
		    && $urandom_range(0, 2) == 0)
			r.write_byte = mirror.cfg_space[r.reg_offset] ^
				(($urandom_range(0, 1) != 0) ? 8'h0F : 8'hF0) & 8'($urandom);
		// hold off the sticky lock until the last phase
		if (r.reg_offset == hbcsd_pkg::OFF_SMRAM)
			r.write_byte[hbcsd_pkg::SMRAM_LOCK] = allow_lock && ($urandom_range(0, 7) == 0);
		r.mem_address = 20'($urandom);
		if ($urandom_range(0, 3) != 0)
			r.mem_address = hbcsd_pkg::ADDR_SMRAM_BASE + 20'($urandom_range(0, 'h5FFFF));
		r.mem_is_write = 1'($urandom);
		return r;
	endfunction

	task automatic send_word(hbcsd_pkg::req_t w);
		start <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic rest(int idle_pct);
		int n;
		n = 0;
		while ($urandom_range(0, 99) < idle_pct)
			n++;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// hold the sender until every expected word is back
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (mirror.pending_rsp.size() != 0);
	endtask

	task automatic run_phase(int count, int idle_pct, bit allow_lock);
		repeat (count) begin
			send_word(random_word(allow_lock));
			rest(idle_pct);
		end
		drain();
	endtask

	task automatic directed_words();
		send_word(mk(hbcsd_pkg::FN_CFG_RD, 3'd0, OFF_ID_LO, 8'h00, 20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_RD, 3'd7, OFF_ID_LO + 8'd2, 8'h00, 20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, OFF_ID_LO, 8'hFF, 20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_RD, 3'd0, OFF_ID_LO, 8'h00, 20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_CMD_LO, 8'hFF,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_STS_HI, 8'h00,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_RO_HI, 8'hFF,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_RO_HI + 8'd1, 8'hA5,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd3, hbcsd_pkg::OFF_RO_HI + 8'd1, 8'h5A,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_RD, 3'd0, hbcsd_pkg::OFF_RO_HI + 8'd1, 8'h00,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_PAM0, 8'h3F,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_PAM0 + 8'd1, 8'h31,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_PAM0 + 8'd1, 8'h35,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00,
			hbcsd_pkg::ADDR_SHADOW_BASE, 1'b0));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00, 20'hC4000, 1'b1));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00, 20'hFFFFF, 1'b1));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00, 20'hEFFFF, 1'b0));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00, 20'h9FFFF, 1'b1));
		send_word(mk(hbcsd_pkg::FN_CFG_WR, 3'd0, hbcsd_pkg::OFF_SMRAM, 8'h48,
			20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00,
			hbcsd_pkg::ADDR_SMRAM_BASE, 1'b0));
		send_word(mk(hbcsd_pkg::FN_SMM_EXIT, 3'd0, 8'h00, 8'h00, 20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00, 20'hBFFFF, 1'b1));
		send_word(mk(hbcsd_pkg::FN_SMM_ENTR, 3'd0, 8'h00, 8'h00, 20'h00000, 1'b0));
		send_word(mk(hbcsd_pkg::FN_DECODE, 3'd0, 8'h00, 8'h00, 20'hBFFFF, 1'b1));
		send_word(mk(FN_RSVD_LO, 3'd0, hbcsd_pkg::OFF_SMRAM, 8'hFF, 20'hFFFFF, 1'b1));
		send_word(mk(FN_RSVD_HI, 3'd0, hbcsd_pkg::OFF_SMRAM, 8'hFF, 20'hFFFFF, 1'b1));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_words();
		run_phase(400, 0, 1'b0);
		run_phase(400, 78, 1'b0);
		run_phase(400, 17, 1'b0);
		run_phase(400, 0, 1'b1);

		repeat (8) @(posedge clk);
		$display("Covered %0d request words and %0d result words: %0d config writes,",
			mirror.words_in, mirror.results, mirror.cfg_writes);
		$display("%0d decode queries, %0d SMM events; SMRAM lock %s at end of run",
			mirror.decodes, mirror.smm_events,
			mirror.cfg_space[hbcsd_pkg::OFF_SMRAM][hbcsd_pkg::SMRAM_LOCK]
				? "set" : "clear");
		if (mirror.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- host_bridge_config_and_shadow_decode_unit.f -----
hw/rtl/hbcsd_pkg.sv
hw/rtl/hbcsd_ram.sv
hw/rtl/host_bridge_config_and_shadow_decode_unit.sv
test/host_bridge_config_and_shadow_decode_unit_test.sv
